// ----- hdl/mhsfm_pkg.sv -----
// Shared types, constants and helpers for the multi-head sensor fault monitor.
`default_nettype none
package mhsfm_pkg;

  localparam int HEADS        = 4;
  localparam int CHECK_PERIOD = 10;
  localparam int LINK_TIMEOUT = 10;
  localparam int MAX_RES      = 4;

  localparam int HEAD_W  = (HEADS > 1) ? $clog2(HEADS) : 1;
  localparam int CNT_W   = $clog2(MAX_RES + 1);
  localparam int FAULT_W = 10;

  localparam logic [15:0] VOLT_HIGH_LEVEL = 16'h00B4;
  localparam logic [15:0] VOLT_LOW_LEVEL  = 16'h0073;
  localparam logic [7:0]  AGE_MAX         = 8'hFF;
  localparam logic [4:0]  ADDR_STEP       = 5'd5;

  localparam int B_IGBT_OPEN  = 0;
  localparam int B_IGBT_SHORT = 1;
  localparam int B_IGBT_HOT   = 2;
  localparam int B_BOT_OPEN   = 3;
  localparam int B_BOT_SHORT  = 4;
  localparam int B_BOT_HOT    = 5;
  localparam int B_COMM       = 6;
  localparam int B_VHIGH      = 7;
  localparam int B_VLOW       = 8;
  localparam int B_HW         = 9;

  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_TICK   = 1'b1;

  typedef enum logic [2:0] {
    REG_IGBT_OPEN,
    REG_IGBT_SHORT,
    REG_IGBT_HOT,
    REG_IGBT_RECOVER,
    REG_BOT_OPEN,
    REG_BOT_SHORT,
    REG_BOT_HOT,
    REG_FAULT_DELAY
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic store;
    logic tick;
    logic check;
    logic emit_step;
    logic emit_beat;
  } cmd_t;

  typedef struct packed {
    logic check_due;
    logic last_head;
    logic emit_ok;
  } sts_t;

  function automatic logic [4:0] addr_of(input logic [HEAD_W-1:0] h);
    return 5'(ADDR_STEP + ADDR_STEP * 5'(h));
  endfunction

endpackage
`default_nettype wire

// ----- hdl/mhsfm_ctrl.sv -----
// Sequencer: idle/accept, per-head check walk, result emission.
`default_nettype none
module mhsfm_ctrl
  import mhsfm_pkg::*;
(
  input  wire  clk,
  input  wire  rst,
  input  wire  s_tvalid,
  output logic s_tready,
  input  wire  s_tuser,
  output logic m_tvalid,
  input  wire  m_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid && s_tuser == FUNC_TICK && sts.check_due) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts.last_head) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts.last_head && (!sts.emit_ok || m_tready)) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    s_tready  = 1'b0;
    m_tvalid  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready  = 1'b1;
        cmd.store = s_tvalid && (s_tuser == FUNC_SAMPLE);
        cmd.tick  = s_tvalid && (s_tuser == FUNC_TICK);
      end
      ST_CHECK: begin
        cmd.check = 1'b1;
      end
      ST_EMIT: begin
        m_tvalid      = sts.emit_ok;
        cmd.emit_step = !sts.emit_ok || m_tready;
        cmd.emit_beat = sts.emit_ok && m_tready;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- hdl/mhsfm_dp.sv -----
// Datapath: config registers, per-head state, check unit and result mux.
`default_nettype none
module mhsfm_dp
  import mhsfm_pkg::*;
(
  input  wire                clk,
  input  wire                rst,
  input  wire                cfg_we,
  input  wire  [2:0]         cfg_index,
  input  wire  [15:0]        cfg_data,
  input  wire  [1:0]         in_head,
  input  wire  [15:0]        in_igbt,
  input  wire  [15:0]        in_bot,
  input  wire  [15:0]        in_volt,
  input  wire                in_online,
  input  cmd_t               cmd,
  output sts_t               sts,
  output logic [HEAD_W-1:0]  out_head,
  output logic [4:0]         out_addr,
  output logic [FAULT_W-1:0] out_fault,
  output logic               out_last
);

  logic [15:0] igbt_open_level, igbt_short_level, igbt_hot_level, igbt_recover_level;
  logic [15:0] bot_open_level, bot_short_level, bot_hot_level;
  logic [7:0]  fault_delay;

  logic [7:0]         period_count;
  logic [HEADS-1:0]   online_flag;
  logic [FAULT_W-1:0] fault_bits [HEADS];
  logic [7:0]         igbt_delay [HEADS];
  logic [7:0]         bot_delay  [HEADS];
  logic [7:0]         comm_delay [HEADS];
  logic [7:0]         link_age   [HEADS];
  logic [15:0]        igbt_store [HEADS];
  logic [15:0]        bot_store  [HEADS];
  logic [15:0]        volt_store [HEADS];

  logic               some_online;
  logic [HEADS-1:0]   changed;
  logic [HEAD_W-1:0]  ptr;
  logic [CNT_W-1:0]   cnt;

  logic [FAULT_W-1:0] fw;
  logic [7:0]         link_age_next, cd, id, bd;
  logic               onl;
  logic               rest;

  // check of head ptr
  always_comb begin
    logic [15:0] iv, bv, vv;
    iv    = igbt_store[ptr];
    bv    = bot_store[ptr];
    vv    = volt_store[ptr];
    fw    = fault_bits[ptr];
    onl   = online_flag[ptr];
    cd    = comm_delay[ptr];
    id    = igbt_delay[ptr];
    bd    = bot_delay[ptr];
    link_age_next = (link_age[ptr] != AGE_MAX) ? link_age[ptr] + 8'd1 : link_age[ptr];

    if (some_online && onl) begin
      fw[B_VHIGH] = vv > VOLT_HIGH_LEVEL;
      fw[B_VLOW]  = vv < VOLT_LOW_LEVEL;
    end

    if (link_age_next > 8'(LINK_TIMEOUT)) begin
      onl = 1'b0;
      if (cd < fault_delay) cd = cd + 8'd1;
      else fw[B_COMM] = 1'b1;
    end else begin
      onl        = 1'b1;
      fw[B_COMM] = 1'b0;
      cd         = '0;
    end

    if (onl) begin
      if (iv <= igbt_open_level) begin
        if (id < fault_delay) id = id + 8'd1;
        else fw[B_IGBT_OPEN] = 1'b1;
        fw[B_IGBT_SHORT] = 1'b0;
      end else if (iv >= igbt_short_level) begin
        if (id < fault_delay) id = id + 8'd1;
        else fw[B_IGBT_SHORT] = 1'b1;
        fw[B_IGBT_OPEN] = 1'b0;
      end else begin
        if (iv > igbt_hot_level) begin
          if (id < fault_delay) id = id + 8'd1;
          else fw[B_IGBT_HOT] = 1'b1;
        end else begin
          if (iv < igbt_recover_level) fw[B_IGBT_HOT] = 1'b0;
          id = '0;
        end
        fw[B_IGBT_OPEN]  = 1'b0;
        fw[B_IGBT_SHORT] = 1'b0;
      end

      if (bv <= bot_open_level) begin
        if (bd < fault_delay) bd = bd + 8'd1;
        else fw[B_BOT_OPEN] = 1'b1;
        fw[B_BOT_SHORT] = 1'b0;
      end else if (bv >= bot_short_level) begin
        if (bd < fault_delay) bd = bd + 8'd1;
        else fw[B_BOT_SHORT] = 1'b1;
        fw[B_BOT_OPEN] = 1'b0;
      end else begin
        if (bv > bot_hot_level) begin
          if (bd < fault_delay) bd = bd + 8'd1;
          else fw[B_BOT_HOT] = 1'b1;
        end else begin
          bd = '0;
        end
        fw[B_BOT_OPEN]  = 1'b0;
        fw[B_BOT_SHORT] = 1'b0;
      end
    end

    fw[B_HW] = fw[B_IGBT_OPEN] | fw[B_IGBT_SHORT] | fw[B_BOT_OPEN] | fw[B_BOT_SHORT];
  end

  always_comb begin
    rest = 1'b0;
    for (int i = 0; i < HEADS; i++) begin
      if (changed[i] && HEAD_W'(i) > ptr) rest = 1'b1;
    end
  end

  assign sts.check_due = ({1'b0, period_count} + 9'd1) >= 9'(CHECK_PERIOD);
  assign sts.last_head = ptr == HEAD_W'(HEADS - 1);
  assign sts.emit_ok   = changed[ptr] && (cnt < CNT_W'(MAX_RES));

  assign out_head  = ptr;
  assign out_addr  = addr_of(ptr);
  assign out_fault = fault_bits[ptr];
  assign out_last  = !rest || (cnt == CNT_W'(MAX_RES - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      igbt_open_level    <= 16'd0;
      igbt_short_level   <= 16'hFFFF;
      igbt_hot_level     <= 16'hFFFF;
      igbt_recover_level <= 16'd0;
      bot_open_level     <= 16'd0;
      bot_short_level    <= 16'hFFFF;
      bot_hot_level      <= 16'hFFFF;
      fault_delay        <= 8'd3;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_IGBT_OPEN:    igbt_open_level    <= cfg_data;
        REG_IGBT_SHORT:   igbt_short_level   <= cfg_data;
        REG_IGBT_HOT:     igbt_hot_level     <= cfg_data;
        REG_IGBT_RECOVER: igbt_recover_level <= cfg_data;
        REG_BOT_OPEN:     bot_open_level     <= cfg_data;
        REG_BOT_SHORT:    bot_short_level    <= cfg_data;
        REG_BOT_HOT:      bot_hot_level      <= cfg_data;
        REG_FAULT_DELAY:  fault_delay        <= cfg_data[7:0];
        default:          fault_delay        <= fault_delay;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      period_count <= '0;
      online_flag  <= '0;
      some_online  <= 1'b0;
      changed      <= '0;
      ptr          <= '0;
      cnt          <= '0;
      for (int i = 0; i < HEADS; i++) begin
        fault_bits[i] <= '0;
        igbt_delay[i] <= '0;
        bot_delay[i]  <= '0;
        comm_delay[i] <= '0;
        link_age[i]   <= AGE_MAX;
        igbt_store[i] <= '0;
        bot_store[i]  <= '0;
        volt_store[i] <= '0;
      end
    end else begin
      if (cmd.store && ({30'd0, in_head} < HEADS)) begin
        igbt_store[in_head[HEAD_W-1:0]]  <= in_igbt;
        bot_store[in_head[HEAD_W-1:0]]   <= in_bot;
        volt_store[in_head[HEAD_W-1:0]]  <= in_volt;
        online_flag[in_head[HEAD_W-1:0]] <= in_online;
        link_age[in_head[HEAD_W-1:0]]    <= '0;
      end
      if (cmd.tick) begin
        if (sts.check_due) begin
          period_count <= '0;
          ptr          <= '0;
          some_online  <= |online_flag;
          changed      <= '0;
        end else begin
          period_count <= period_count + 8'd1;
        end
      end
      if (cmd.check) begin
        fault_bits[ptr]  <= fw;
        online_flag[ptr] <= onl;
        comm_delay[ptr]  <= cd;
        igbt_delay[ptr]  <= id;
        bot_delay[ptr]   <= bd;
        link_age[ptr]    <= link_age_next;
        changed[ptr]     <= fw != fault_bits[ptr];
        ptr              <= sts.last_head ? '0 : ptr + HEAD_W'(1);
        cnt              <= '0;
      end
      if (cmd.emit_step) begin
        ptr <= sts.last_head ? '0 : ptr + HEAD_W'(1);
      end
      if (cmd.emit_beat) begin
        cnt <= cnt + CNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ----- hdl/multi_head_sensor_fault_monitor_core.sv -----
// Top level: multi-head sensor fault monitor, stream in/out plus config writes.
//
// Input beats (s_*): s_tuser selects a sample update (0) or a 10 ms tick (1).
// A sample update stores one head's readings and online flag and restarts its
// link age and produces nothing. A tick advances the period counter; every
// CHECK_PERIOD ticks a check runs. A check walks the heads one per cycle
// (one shared check unit), then walks them again to emit one output beat per
// head whose fault word changed, in rising head order, tlast on the final one.
// s_tready is low during a check and its emission; a stalled receiver holds
// the block in the emit walk with the beat steady on m_*.
// Config writes (cfg_we, cfg_index, cfg_data) take effect at the next edge.
// Synchronous reset restores thresholds to defaults, clears all fault state,
// and sets every head's link age to its maximum.
`default_nettype none
module multi_head_sensor_fault_monitor_core
  import mhsfm_pkg::*;
(
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [55:0] s_tdata,   // head[1:0], igbt_reading, bot_reading, volt_reading, link_online
  input  wire         s_tuser,   // func
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [23:0] m_tdata,   // head[1:0], slave_address[4:0], fault_word[9:0]
  output logic        m_tlast,
  input  wire         cfg_we,
  input  wire  [2:0]  cfg_index,
  input  wire  [15:0] cfg_data
);

  cmd_t               cmd;
  sts_t               sts;
  logic [HEAD_W-1:0]  out_head;
  logic [4:0]         out_addr;
  logic [FAULT_W-1:0] out_fault;

  mhsfm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mhsfm_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_head   (s_tdata[1:0]),
    .in_igbt   (s_tdata[17:2]),
    .in_bot    (s_tdata[33:18]),
    .in_volt   (s_tdata[49:34]),
    .in_online (s_tdata[50]),
    .cmd       (cmd),
    .sts       (sts),
    .out_head  (out_head),
    .out_addr  (out_addr),
    .out_fault (out_fault),
    .out_last  (m_tlast)
  );

  assign m_tdata = {7'd0, out_fault, out_addr, 2'(out_head)};

endmodule
`default_nettype wire

// ----- tb/sv/testbench.sv -----
// Testbench for the multi-head sensor fault monitor: table-driven and random beats vs. a predictor.
`timescale 1ns / 100ps
module testbench;
  import mhsfm_pkg::*;

  localparam int LIMIT_CYCLES  = 200000;
  localparam int SETTLE_CYCLES = 24;
  localparam int HOLD_CYCLES   = 400;
  localparam int PHASES        = 5;
  localparam int PHASE_BEATS   = 46;

  typedef struct packed {
    logic [1:0] head;
    logic [4:0] addr;
    logic [9:0] word;
    logic       last;
  } fault_report_t;

  typedef struct packed {
    logic        fn;
    logic [1:0]  hd;
    logic [15:0] ig;
    logic [15:0] bt;
    logic [15:0] vt;
    logic        on;
  } sensor_beat_t;

  typedef struct packed {
    sensor_beat_t    beat;
    logic [7:0]      reps;
    logic            typed;
    logic [3:0]      rpt;
    logic [3:0][9:0] words;
  } plan_row_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic [55:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tready = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  wire         s_tready;
  wire         m_tvalid;
  wire  [23:0] m_tdata;
  wire         m_tlast;

  multi_head_sensor_fault_monitor_core dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // predictor state
  logic [15:0] lv_igbt_open, lv_igbt_short, lv_igbt_hot, lv_igbt_recover;
  logic [15:0] lv_bot_open, lv_bot_short, lv_bot_hot;
  logic [7:0]  lv_delay;
  logic [7:0]  tick_cnt;
  logic        online_q [HEADS];
  logic [9:0]  faults_q [HEADS];
  logic [7:0]  igbt_dly [HEADS];
  logic [7:0]  bot_dly  [HEADS];
  logic [7:0]  comm_dly [HEADS];
  logic [7:0]  age_q    [HEADS];
  logic [15:0] igbt_q   [HEADS];
  logic [15:0] bot_q    [HEADS];
  logic [15:0] volt_q   [HEADS];

  fault_report_t fresh_reports[$];
  fault_report_t due_reports[$];

  int   errors = 0;
  int   beats_sent = 0;
  int   reports_seen = 0;
  int   checks_run = 0;
  int   hold_asks = 0;
  int   cycles = 0;
  logic calm = 1'b0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic note_miss(input string what, input fault_report_t want, input fault_report_t got);
    errors++;
    if (errors <= 10)
      $display("%s: expected head %0d addr %0d word %h last %b, got head %0d addr %0d word %h last %b",
               what, want.head, want.addr, want.word, want.last,
               got.head, got.addr, got.word, got.last);
  endtask

  task automatic reset_monitor();
    lv_igbt_open    = 16'h0000;
    lv_igbt_short   = 16'hFFFF;
    lv_igbt_hot     = 16'hFFFF;
    lv_igbt_recover = 16'h0000;
    lv_bot_open     = 16'h0000;
    lv_bot_short    = 16'hFFFF;
    lv_bot_hot      = 16'hFFFF;
    lv_delay        = 8'd3;
    tick_cnt        = '0;
    for (int h = 0; h < HEADS; h++) begin
      online_q[h] = 1'b0;
      faults_q[h] = '0;
      igbt_dly[h] = '0;
      bot_dly[h]  = '0;
      comm_dly[h] = '0;
      age_q[h]    = AGE_MAX;
      igbt_q[h]   = '0;
      bot_q[h]    = '0;
      volt_q[h]   = '0;
    end
  endtask

  // open/short/hot share one debounce counter; bits at base, base+1, base+2
  task automatic sensor_check(input logic [15:0] v, lo, hi, hot, rec, input logic can_rec,
                              input int base, inout logic [7:0] dly, inout logic [9:0] w);
    int   b;
    logic count;
    count = 1'b0;
    b = base;
    if (v <= lo) begin
      count = 1'b1;
      w[base+1] = 1'b0;
    end else if (v >= hi) begin
      count = 1'b1;
      b = base + 1;
      w[base] = 1'b0;
    end else begin
      w[base] = 1'b0;
      w[base+1] = 1'b0;
      if (v > hot) begin
        count = 1'b1;
        b = base + 2;
      end else begin
        if (can_rec && v < rec) w[base+2] = 1'b0;
        dly = '0;
      end
    end
    if (count) begin
      if (dly < lv_delay) dly++;
      else w[b] = 1'b1;
    end
  endtask

  task automatic advance_monitor(input sensor_beat_t b);
    logic [9:0]    old_w [HEADS];
    logic [9:0]    w;
    logic [7:0]    d;
    logic          any_on;
    fault_report_t r;
    fresh_reports.delete();
    if (b.fn == FUNC_SAMPLE) begin
      if (b.hd < HEADS) begin
        igbt_q[b.hd]   = b.ig;
        bot_q[b.hd]    = b.bt;
        volt_q[b.hd]   = b.vt;
        online_q[b.hd] = b.on;
        age_q[b.hd]    = '0;
      end
      return;
    end
    tick_cnt = tick_cnt + 8'd1;
    if (tick_cnt < CHECK_PERIOD) return;
    tick_cnt = '0;
    checks_run++;
    any_on = 1'b0;
    for (int h = 0; h < HEADS; h++) begin
      old_w[h] = faults_q[h];
      any_on = any_on | online_q[h];
    end
    for (int h = 0; h < HEADS; h++) begin
      if (any_on && online_q[h]) begin
        faults_q[h][B_VHIGH] = volt_q[h] > VOLT_HIGH_LEVEL;
        faults_q[h][B_VLOW]  = volt_q[h] < VOLT_LOW_LEVEL;
      end
    end
    for (int h = 0; h < HEADS; h++) begin
      w = faults_q[h];
      if (age_q[h] < AGE_MAX) age_q[h]++;
      if (age_q[h] > LINK_TIMEOUT) begin
        online_q[h] = 1'b0;
        if (comm_dly[h] < lv_delay) comm_dly[h]++;
        else w[B_COMM] = 1'b1;
      end else begin
        online_q[h] = 1'b1;
        w[B_COMM] = 1'b0;
        comm_dly[h] = '0;
      end
      if (online_q[h]) begin
        d = igbt_dly[h];
        sensor_check(igbt_q[h], lv_igbt_open, lv_igbt_short, lv_igbt_hot, lv_igbt_recover,
                     1'b1, B_IGBT_OPEN, d, w);
        igbt_dly[h] = d;
        d = bot_dly[h];
        sensor_check(bot_q[h], lv_bot_open, lv_bot_short, lv_bot_hot, 16'h0000,
                     1'b0, B_BOT_OPEN, d, w);
        bot_dly[h] = d;
      end
      w[B_HW] = w[B_IGBT_OPEN] | w[B_IGBT_SHORT] | w[B_BOT_OPEN] | w[B_BOT_SHORT];
      faults_q[h] = w;
      if (w != old_w[h] && fresh_reports.size() < MAX_RES) begin
        r.head = 2'(h);
        r.addr = ADDR_STEP + ADDR_STEP * 5'(h);
        r.word = w;
        r.last = 1'b0;
        fresh_reports.push_back(r);
      end
    end
    if (fresh_reports.size() > 0) begin
      r = fresh_reports.pop_back();
      r.last = 1'b1;
      fresh_reports.push_back(r);
    end
  endtask

  task automatic write_reg(input cfg_reg_t r, input logic [15:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= r;
    cfg_data  <= v;
    @(posedge clk);
    case (r)
      REG_IGBT_OPEN:    lv_igbt_open    = v;
      REG_IGBT_SHORT:   lv_igbt_short   = v;
      REG_IGBT_HOT:     lv_igbt_hot     = v;
      REG_IGBT_RECOVER: lv_igbt_recover = v;
      REG_BOT_OPEN:     lv_bot_open     = v;
      REG_BOT_SHORT:    lv_bot_short    = v;
      REG_BOT_HOT:      lv_bot_hot      = v;
      REG_FAULT_DELAY:  lv_delay        = v[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic program_levels(input logic [15:0] io, is, ih, ir, bo, bs, bh,
                                input logic [7:0] d);
    write_reg(REG_IGBT_OPEN, io);
    write_reg(REG_IGBT_SHORT, is);
    write_reg(REG_IGBT_HOT, ih);
    write_reg(REG_IGBT_RECOVER, ir);
    write_reg(REG_BOT_OPEN, bo);
    write_reg(REG_BOT_SHORT, bs);
    write_reg(REG_BOT_HOT, bh);
    write_reg(REG_FAULT_DELAY, {8'h00, d});
  endtask

  // drop valid, wait for every report, then let a silent check finish
  task automatic settle_block();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (due_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_beat(input sensor_beat_t b, input logic typed, input logic [3:0] rpt,
                           input logic [3:0][9:0] words);
    fault_report_t want;
    int            n;
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < 6) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= b.fn;
    s_tdata  <= {5'b0, b.on, b.vt, b.bt, b.ig, b.hd};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    beats_sent++;
    advance_monitor(b);
    if (typed) begin
      n = 0;
      for (int h = 0; h < HEADS; h++) begin
        if (rpt[h]) begin
          want.head = 2'(h);
          want.addr = ADDR_STEP + ADDR_STEP * 5'(h);
          want.word = words[h];
          want.last = (rpt >> (h + 1)) == 4'd0;
          if (n >= fresh_reports.size()) note_miss("table vs prediction", want, '0);
          else if (fresh_reports[n] != want)
            note_miss("table vs prediction", want, fresh_reports[n]);
          due_reports.push_back(want);
          n++;
        end
      end
      if (n < fresh_reports.size()) note_miss("table lacks report", '0, fresh_reports[n]);
    end else begin
      foreach (fresh_reports[k]) due_reports.push_back(fresh_reports[k]);
    end
  endtask

  function automatic logic [15:0] pick_reading(input logic [15:0] a, b, c, d);
    logic [15:0] off;
    logic [15:0] v;
    off = 16'($urandom_range(0, 4)) - 16'd2;
    case ($urandom_range(0, 5))
      0: v = 16'($urandom);
      1: v = a + off;
      2: v = b + off;
      3: v = c + off;
      4: v = d + off;
      default: v = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
    endcase
    return v;
  endfunction

  function automatic plan_row_t row(input logic fn, input logic [1:0] hd,
                                    input logic [15:0] ig, bt, vt, input logic on,
                                    input int reps, input logic typed, input logic [3:0] rpt,
                                    input logic [3:0][9:0] words);
    plan_row_t p;
    p.beat  = {fn, hd, ig, bt, vt, on};
    p.reps  = 8'(reps);
    p.typed = typed;
    p.rpt   = rpt;
    p.words = words;
    return p;
  endfunction

  // sink: random stalls, plus one long hold-off on request
  initial begin : sink
    int held;
    int seen;
    held = 0;
    seen = 0;
    forever begin
      @(negedge clk);
      if (hold_asks != seen) begin
        seen = hold_asks;
        held = HOLD_CYCLES;
      end
      if (held > 0) begin
        held--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= calm || ($urandom_range(0, 99) >= 6);
      end
    end
  end

  always @(posedge clk) begin : report_check
    fault_report_t got;
    fault_report_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tdata[1:0], m_tdata[6:2], m_tdata[16:7], m_tlast};
      reports_seen++;
      if (due_reports.size() == 0) begin
        note_miss("unexpected report", '0, got);
      end else begin
        want = due_reports.pop_front();
        if (got !== want) note_miss("report mismatch", want, got);
      end
    end
  end

  initial begin : watchdog
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("multi_head_sensor_fault_monitor_core test failed");
    $finish;
  end

  initial begin : main_seq
    plan_row_t    plan[$];
    sensor_beat_t b;
    logic [15:0]  io, is, ih, ir, bo, bs, bh;
    logic [7:0]   d;
    reset_monitor();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    program_levels(16'd100, 16'd60000, 16'd5000, 16'd4000,
                   16'd100, 16'd60000, 16'd5000, 8'd0);

    // open/short/volt extremes; head 2 offline during volt check; head 3 never heard
    plan.push_back(row(FUNC_SAMPLE, 2'd0, 16'h0000, 16'hFFFF, 16'h00B5, 1'b1, 1, 1'b0, 4'b0, '0));
    plan.push_back(row(FUNC_SAMPLE, 2'd1, 16'd1000, 16'd1000, 16'h0072, 1'b1, 1, 1'b0, 4'b0, '0));
    plan.push_back(row(FUNC_SAMPLE, 2'd2, 16'hFFFF, 16'h0000, 16'h0073, 1'b0, 1, 1'b0, 4'b0, '0));
    plan.push_back(row(FUNC_TICK, 2'd0, 16'h0000, 16'h0000, 16'h0000, 1'b0, 10, 1'b1, 4'b1111,
                       {10'h040, 10'h20A, 10'h100, 10'h291}));
    // hot, threshold boundaries, volt-only change
    plan.push_back(row(FUNC_SAMPLE, 2'd0, 16'd5001, 16'd5001, 16'h00B4, 1'b1, 1, 1'b0, 4'b0, '0));
    plan.push_back(row(FUNC_SAMPLE, 2'd1, 16'd100, 16'd60000, 16'h0073, 1'b1, 1, 1'b0, 4'b0, '0));
    plan.push_back(row(FUNC_SAMPLE, 2'd2, 16'd60000, 16'd101, 16'hFFFF, 1'b1, 1, 1'b0, 4'b0, '0));
    plan.push_back(row(FUNC_SAMPLE, 2'd3, 16'd4999, 16'd4999, 16'h0000, 1'b1, 1, 1'b0, 4'b0, '0));
    plan.push_back(row(FUNC_TICK, 2'd1, 16'h0000, 16'h0000, 16'h0000, 1'b1, 10, 1'b0, 4'b0, '0));
    // igbt below recover, bottom still hot; lone tick gives nothing
    plan.push_back(row(FUNC_SAMPLE, 2'd0, 16'd3999, 16'd5001, 16'h0080, 1'b1, 1, 1'b0, 4'b0, '0));
    plan.push_back(row(FUNC_TICK, 2'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1, 1'b1, 4'b0, '0));

    foreach (plan[r])
      for (int k = 0; k < plan[r].reps; k++)
        send_beat(plan[r].beat, plan[r].typed && (k == plan[r].reps - 1),
                  plan[r].rpt, plan[r].words);

    for (int p = 0; p < PHASES; p++) begin
      settle_block();
      case (p)
        1: program_levels(16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000,
                          16'h0000, 16'hFFFF, 16'hFFFF, 8'd255);
        2: program_levels(16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF,
                          16'h0000, 16'h0000, 16'h0000, 8'($urandom_range(1, 3)));
        default: begin
          io = 16'($urandom_range(0, 3000));
          is = 16'($urandom_range(50000, 65535));
          ih = 16'($urandom_range(4000, 45000));
          ir = ih - 16'($urandom_range(0, 3000));
          bo = 16'($urandom_range(0, 3000));
          bs = 16'($urandom_range(50000, 65535));
          bh = 16'($urandom_range(4000, 45000));
          d  = (p == 0) ? 8'd0 : 8'($urandom_range(0, 4));
          program_levels(io, is, ih, ir, bo, bs, bh, d);
        end
      endcase
      calm = (p == 1);
      for (int i = 0; i < PHASE_BEATS; i++) begin
        if (p == 2 && i == 8) hold_asks++;
        b.fn = ($urandom_range(0, 99) < 72) ? FUNC_TICK : FUNC_SAMPLE;
        // head 3 stays silent until the last phase so its link times out
        b.hd = (p < PHASES - 1) ? 2'($urandom_range(0, 2)) : 2'($urandom_range(0, 3));
        b.ig = pick_reading(lv_igbt_open, lv_igbt_short, lv_igbt_hot, lv_igbt_recover);
        b.bt = pick_reading(lv_bot_open, lv_bot_short, lv_bot_hot, lv_bot_hot);
        b.vt = pick_reading(VOLT_LOW_LEVEL, VOLT_HIGH_LEVEL, 16'h0000, 16'h0100);
        b.on = $urandom_range(0, 9) != 0;
        send_beat(b, 1'b0, 4'b0, '0);
      end
    end
    calm = 1'b0;
    settle_block();

    $display("%0d beats driven over %0d check periods, %0d fault reports compared",
             beats_sent, checks_run, reports_seen);
    $display("level sets: directed, random x3, all-default with max delay, inverted; one long sink hold");
    if (errors == 0 && due_reports.size() == 0) begin
      $display("multi_head_sensor_fault_monitor_core test passed");
    end else begin
      $display("multi_head_sensor_fault_monitor_core test failed");
    end
    $finish;
  end

endmodule
